// ----- sv/fsj_pkg.sv -----
// ----------------------------------------------------------------------------
// fsj_pkg
// Shared types and constants for the four-sum hash join unit: stream field
// layout, command codes, table entry format and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package fsj_pkg;

    localparam int IN_VAL_W        = 12;  // element width on the stream
    localparam int IDX_W           = 9;   // index width on the stream
    localparam int CMD_W           = 2;
    localparam int DEF_ELEM_WIDTH  = 12;

    // s_tdata layout, lowest bit first: cmd, value_x, value_y, index_x, index_y
    localparam int S_CMD_LO  = 0;
    localparam int S_VX_LO   = S_CMD_LO + CMD_W;
    localparam int S_VY_LO   = S_VX_LO + IN_VAL_W;
    localparam int S_IX_LO   = S_VY_LO + IN_VAL_W;
    localparam int S_IY_LO   = S_IX_LO + IDX_W;
    localparam int S_USED_W  = S_IY_LO + IDX_W;
    localparam int S_DATA_W  = ((S_USED_W + 7) / 8) * 8;

    // m_tdata layout, lowest bit first: index_a, index_b, index_c, index_d
    localparam int M_USED_W  = 4 * IDX_W;
    localparam int M_DATA_W  = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_BUILD = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_CLEAR = 2'd2
    } fsj_cmd_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
    } fsj_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input transaction taken this cycle
        logic resolve;   // finish the pending build/probe
        logic clr_step;  // clear one table entry
    } fsj_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic in_is_clear;  // command on the input bus is a clear
        logic clr_last;     // clear sweep is at the final entry
        logic out_stall;    // probe hit waits for the output register
    } fsj_stat_t;

endpackage

`default_nettype wire

// ----- sv/fsj_ctrl.sv -----
// ----------------------------------------------------------------------------
// fsj_ctrl
// Controller: sweeps the table clear after reset and on a clear command,
// accepts one transaction at a time and sequences its lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module fsj_ctrl
    import fsj_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire fsj_stat_t stat,
    output fsj_ctl_t       ctl
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        ctl.accept   = 1'b0;
        ctl.resolve  = 1'b0;
        ctl.clr_step = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.accept = 1'b1;
                    state_next = stat.in_is_clear ? ST_CLEAR : ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // hold while a probe hit cannot reach the output register
                if (!stat.out_stall) begin
                    ctl.resolve = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/fsj_datapath.sv -----
// ----------------------------------------------------------------------------
// fsj_datapath
// Datapath: element saturation, pair sum and table address, the sum table
// memory with its registered read port, clear counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsj_datapath
    import fsj_pkg::*;
#(
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    input  wire fsj_ctl_t            ctl,
    output fsj_stat_t                stat
);

    localparam int XW     = (ELEM_WIDTH > IN_VAL_W) ? ELEM_WIDTH : IN_VAL_W;
    localparam int SUM_W  = ELEM_WIDTH + 2;
    localparam int ADDR_W = ELEM_WIDTH + 1;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic signed [XW-1:0] SAT_HI = XW'((1 << (ELEM_WIDTH - 1)) - 1);
    localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);
    localparam logic [SUM_W-1:0]     OFFSET = {2'b01, {ELEM_WIDTH{1'b0}}};

    // input fields
    logic [CMD_W-1:0]           in_cmd;
    logic signed [IN_VAL_W-1:0] in_vx, in_vy;
    logic [IDX_W-1:0]           in_ix, in_iy;

    assign in_cmd = s_tdata[S_CMD_LO +: CMD_W];
    assign in_vx  = s_tdata[S_VX_LO +: IN_VAL_W];
    assign in_vy  = s_tdata[S_VY_LO +: IN_VAL_W];
    assign in_ix  = s_tdata[S_IX_LO +: IDX_W];
    assign in_iy  = s_tdata[S_IY_LO +: IDX_W];

    logic signed [XW-1:0]         ext_x, ext_y;
    logic signed [ELEM_WIDTH-1:0] sat_x, sat_y;
    logic signed [SUM_W-1:0]      pair_sum;
    logic [SUM_W-1:0]             build_slot, probe_slot;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         probe_in_range;

    always_comb begin
        ext_x = XW'(in_vx);
        ext_y = XW'(in_vy);
        if (ext_x > SAT_HI) begin
            ext_x = SAT_HI;
        end else if (ext_x < SAT_LO) begin
            ext_x = SAT_LO;
        end
        if (ext_y > SAT_HI) begin
            ext_y = SAT_HI;
        end else if (ext_y < SAT_LO) begin
            ext_y = SAT_LO;
        end
        sat_x = ELEM_WIDTH'(ext_x);
        sat_y = ELEM_WIDTH'(ext_y);
    end

    assign pair_sum       = SUM_W'(sat_x) + SUM_W'(sat_y);
    assign build_slot     = pair_sum + OFFSET;
    assign probe_slot     = OFFSET - pair_sum;
    // a negated sum of +2^ELEM_WIDTH lands one past the table
    assign probe_in_range = !probe_slot[SUM_W-1];
    assign rd_addr        = (in_cmd == CMD_BUILD) ? build_slot[ADDR_W-1:0]
                                                  : probe_slot[ADDR_W-1:0];

    // pending item
    logic [CMD_W-1:0]  cmd_reg;
    logic [IDX_W-1:0]  ix_reg, iy_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic              in_range_reg;
    fsj_entry_t        rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            cmd_reg      <= in_cmd;
            ix_reg       <= in_ix;
            iy_reg       <= in_iy;
            slot_reg     <= rd_addr;
            in_range_reg <= probe_in_range;
        end
    end

    // sum table
    fsj_entry_t        mem [DEPTH];
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    fsj_entry_t        wr_data;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              is_build, is_probe, probe_hit, ld_out;

    assign is_build  = (cmd_reg == CMD_BUILD);
    assign is_probe  = (cmd_reg == CMD_PROBE);
    assign probe_hit = is_probe && in_range_reg && rd_data_reg.valid;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = '{valid: 1'b1, idx_a: ix_reg, idx_b: iy_reg};
        if (ctl.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end else if (ctl.resolve && is_build && !rd_data_reg.valid) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    logic [ADDR_W-1:0] clr_cnt_next;
    assign clr_cnt_next = clr_cnt_reg + ADDR_W'(1);

    // wraps back to zero at the end of each sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (ctl.clr_step) begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_USED_W-1:0] m_data_reg;

    assign ld_out = ctl.resolve && probe_hit;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (ld_out) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_data_reg <= {iy_reg, ix_reg, rd_data_reg.idx_b, rd_data_reg.idx_a};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

    assign stat.in_is_clear = (in_cmd == CMD_CLEAR);
    assign stat.clr_last    = &clr_cnt_reg;
    assign stat.out_stall   = probe_hit && m_tvalid_reg && !m_tready;

    a_rise_after_resolve: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(ctl.resolve) && $past(probe_hit))
        else $error("result appeared without a resolved probe hit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_out |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten before it was taken");

    a_clear_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clr_step |-> !ctl.resolve && !ctl.accept)
        else $error("clear sweep overlaps item processing");

    a_clear_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.clr_step && stat.clr_last) |=> (clr_cnt_reg == '0))
        else $error("clear counter did not return to zero");

endmodule

`default_nettype wire

// ----- sv/four_sum_hash_join_unit.sv -----
// ----------------------------------------------------------------------------
// four_sum_hash_join_unit
// Build-and-probe engine for the zero four-sum, with a sum table addressed
// directly by the pair sum.
//
//   channel  ports      fields (lowest bit up)
//   -------  ---------  ------------------------------------------------------
//   input    s_t*       tdata: cmd[1:0] value_x[13:2] value_y[25:14]
//                              index_x[34:26] index_y[43:35]
//   result   m_t*       tdata: index_a[8:0] index_b[17:9] index_c[26:18]
//                              index_d[35:27]
//
// Build and probe each run as an accept, then the registered read of the
// single-port sum table returns and the entry is written (a build only into an
// empty slot) or matched. Clear writes all 2^(ELEM_WIDTH+1) table entries (8192
// at the default) after its accept, one table entry per cycle. The same sweep
// runs after reset before s_tready rises. A probe hit waits in its lookup cycle
// while the output register holds an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none

module four_sum_hash_join_unit
    import fsj_pkg::*;
#(
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // cmd, value_x, value_y, index_x, index_y
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // index_a, index_b, index_c, index_d
    output logic [M_DATA_W-1:0]      m_tdata
);

    fsj_ctl_t  ctl;
    fsj_stat_t stat;

    fsj_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    fsj_datapath #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctl      (ctl),
        .stat     (stat)
    );

endmodule

`default_nettype wire
